### hdl/acpu_pkg.sv
// Package for the accumulator CPU execute block.
// Opcodes, jump conditions, the reset program counter and the execute result struct.
// No dependencies.
package acpu_pkg;

    localparam int DATA_W  = 8;
    localparam int ADDR_W  = 16;
    localparam int REG_CNT = 8;
    localparam int RIDX_W  = $clog2(REG_CNT);

    localparam logic [ADDR_W-1:0] PC_RESET = 16'hFE00;

    localparam logic [3:0] OP_LOAD  = 4'd1;
    localparam logic [3:0] OP_STORE = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_JUMP  = 4'd5;
    localparam logic [3:0] OP_OR    = 4'd6;
    localparam logic [3:0] OP_NAND  = 4'd7;
    localparam logic [3:0] OP_CMP   = 4'd8;

    localparam logic [RIDX_W-1:0] JC_ZERO     = 3'd1;
    localparam logic [RIDX_W-1:0] JC_CARRY    = 3'd2;
    localparam logic [RIDX_W-1:0] JC_EITHER   = 3'd3;
    localparam logic [RIDX_W-1:0] JC_NOT_ZERO = 3'd4;

    typedef struct packed {
        logic                   reg_we;
        logic [RIDX_W-1:0]      reg_waddr;
        logic [DATA_W-1:0]      reg_wdata;
        logic                   zero;
        logic                   carry;
        logic [ADDR_W-1:0]      pc;
        logic                   store_en;
        logic [ADDR_W-1:0]      store_addr;
        logic [DATA_W-1:0]      store_byte;
    } acpu_exec_t;

endpackage

### hdl/acpu_regfile.sv
// Register file of the accumulator CPU: eight 8-bit registers, cleared by reset.
// One write port, one indexed read port and a fixed read of register 0.
// Depends on acpu_pkg.
module acpu_regfile
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             we,
    input  logic [acpu_pkg::RIDX_W-1:0]      waddr,
    input  logic [acpu_pkg::DATA_W-1:0]      wdata,
    input  logic [acpu_pkg::RIDX_W-1:0]      raddr,
    output logic [acpu_pkg::DATA_W-1:0]      rdata,
    output logic [acpu_pkg::DATA_W-1:0]      acc
);
    import acpu_pkg::*;

    logic [DATA_W-1:0] regs_reg [REG_CNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_CNT; i++)
            begin
                regs_reg[i] <= '0;
            end
        end
        else if (we)
        begin
            regs_reg[waddr] <= wdata;
        end
    end

    assign rdata = regs_reg[raddr];
    assign acc   = regs_reg[0];

endmodule

### hdl/acpu_exec.sv
// Execute logic of the accumulator CPU: decode, 8-bit ALU, jump test and pc update.
// Purely combinational; returns the state updates and store request as one struct.
// Depends on acpu_pkg.
module acpu_exec
(
    input  logic [acpu_pkg::DATA_W-1:0]      instruction,
    input  logic [acpu_pkg::DATA_W-1:0]      operand_high,
    input  logic [acpu_pkg::DATA_W-1:0]      operand_low,
    input  logic [acpu_pkg::DATA_W-1:0]      memory_data,
    input  logic [acpu_pkg::DATA_W-1:0]      reg_r,
    input  logic [acpu_pkg::DATA_W-1:0]      reg_acc,
    input  logic                             zero_in,
    input  logic                             carry_in,
    input  logic [acpu_pkg::ADDR_W-1:0]      pc_in,
    output acpu_pkg::acpu_exec_t             result
);
    import acpu_pkg::*;

    logic [3:0]        op;
    logic              mm;
    logic [RIDX_W-1:0] ri;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic              sub;
    logic [DATA_W:0]   sum;
    logic [DATA_W-1:0] logic_res;
    logic              take;
    logic [1:0]        step;

    assign op   = instruction[7:4];
    assign mm   = instruction[3];
    assign ri   = instruction[RIDX_W-1:0];
    assign addr = {operand_high, operand_low};

    always_comb
    begin
        opa = mm ? reg_r : reg_acc;
        opb = mm ? memory_data : reg_r;
        if (op == OP_CMP && mm)
        begin
            opa = memory_data;
            opb = reg_r;
        end
    end

    assign sub       = (op == OP_SUB) || (op == OP_CMP);
    assign sum       = {1'b0, opa} + {1'b0, sub ? ~opb : opb} + {{DATA_W{1'b0}}, sub};
    assign logic_res = (op == OP_OR) ? (opa | opb) : ~(opa & opb);

    always_comb
    begin
        case (ri)
            JC_ZERO:     take = zero_in;
            JC_CARRY:    take = carry_in;
            JC_EITHER:   take = zero_in | carry_in;
            JC_NOT_ZERO: take = ~zero_in;
            default:     take = 1'b1;
        endcase
    end

    always_comb
    begin
        result            = '0;
        result.reg_waddr  = '0;
        result.zero       = zero_in;
        result.carry      = carry_in;
        step              = mm ? 2'd3 : 2'd1;
        result.pc         = '0;
        case (op)
            OP_LOAD:
            begin
                result.reg_we    = 1'b1;
                result.reg_waddr = ri;
                result.reg_wdata = mm ? memory_data : operand_high;
                step             = mm ? 2'd3 : 2'd2;
            end
            OP_STORE:
            begin
                result.store_en   = 1'b1;
                result.store_addr = addr;
                result.store_byte = reg_r;
                step              = 2'd3;
            end
            OP_ADD:
            begin
                result.reg_we    = 1'b1;
                result.reg_wdata = sum[DATA_W-1:0];
                result.zero      = (sum[DATA_W-1:0] == '0);
                result.carry     = sum[DATA_W];
            end
            OP_SUB, OP_CMP:
            begin
                result.reg_we    = (op == OP_SUB);
                result.reg_wdata = sum[DATA_W-1:0];
                result.zero      = (sum[DATA_W-1:0] == '0);
                result.carry     = ~sum[DATA_W];
            end
            OP_JUMP:
            begin
                step = 2'd3;
                if (take)
                begin
                    step         = 2'd0;
                    result.zero  = 1'b0;
                    result.carry = 1'b0;
                end
            end
            OP_OR, OP_NAND:
            begin
                result.reg_we    = 1'b1;
                result.reg_wdata = logic_res;
                result.zero      = (logic_res == '0);
                result.carry     = 1'b0;
            end
            default:
            begin
                step = 2'd1;
            end
        endcase
        result.pc = ((op == OP_JUMP) && take ? addr : pc_in) + {{(ADDR_W-2){1'b0}}, step};
    end

endmodule

### hdl/accumulator_cpu_execute.sv
// Top level of the accumulator CPU execute block: input register, execute logic, result register.
// Holds the flags and program counter; instantiates acpu_regfile and acpu_exec.
// Depends on acpu_pkg.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  instruction, operand_high, operand_low, memory_data
//   output   out_valid/ out_stall next_pc, store_valid, store_address, store_data,
//                                 accumulator, zero_flag, carry_flag
//
// One instruction per cycle sustained unless the output stalls; the result is registered.
// The execute step (8-bit ALU and pc adder) lies between the input and result registers.
// Reset clears the register file, the valid bits and the flags and sets the program counter to 0xFE00.
// An output stall holds the result; the input register still fills and then stalls the input.
module accumulator_cpu_execute
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [acpu_pkg::DATA_W-1:0]      instruction,
    input  logic [acpu_pkg::DATA_W-1:0]      operand_high,
    input  logic [acpu_pkg::DATA_W-1:0]      operand_low,
    input  logic [acpu_pkg::DATA_W-1:0]      memory_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [acpu_pkg::ADDR_W-1:0]      next_pc,
    output logic                             store_valid,
    output logic [acpu_pkg::ADDR_W-1:0]      store_address,
    output logic [acpu_pkg::DATA_W-1:0]      store_data,
    output logic [acpu_pkg::DATA_W-1:0]      accumulator,
    output logic                             zero_flag,
    output logic                             carry_flag
);
    import acpu_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [DATA_W-1:0] ins_reg;
    logic [DATA_W-1:0] hi_reg;
    logic [DATA_W-1:0] lo_reg;
    logic [DATA_W-1:0] mem_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [ADDR_W-1:0] out_pc_reg;
    logic              out_st_reg;
    logic [ADDR_W-1:0] out_addr_reg;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_acc_reg;
    logic              out_z_reg;
    logic              out_c_reg;

    logic              zero_reg;
    logic              carry_reg;
    logic [ADDR_W-1:0] pc_reg;

    logic              out_space;
    logic              advance;
    logic              in_xfer;
    logic [DATA_W-1:0] reg_r;
    logic [DATA_W-1:0] reg_acc;
    acpu_exec_t        ex;

    assign out_space = ~out_valid_reg | ~out_stall;
    assign advance   = s1_valid_reg & out_space;
    assign in_stall  = s1_valid_reg & ~out_space;
    assign in_xfer   = in_valid & ~in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = advance | (out_valid_reg & out_stall);
    end

    acpu_regfile u_regfile
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (advance & ex.reg_we),
        .waddr (ex.reg_waddr),
        .wdata (ex.reg_wdata),
        .raddr (ins_reg[RIDX_W-1:0]),
        .rdata (reg_r),
        .acc   (reg_acc)
    );

    acpu_exec u_exec
    (
        .instruction  (ins_reg),
        .operand_high (hi_reg),
        .operand_low  (lo_reg),
        .memory_data  (mem_reg),
        .reg_r        (reg_r),
        .reg_acc      (reg_acc),
        .zero_in      (zero_reg),
        .carry_in     (carry_reg),
        .pc_in        (pc_reg),
        .result       (ex)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            zero_reg      <= 1'b0;
            carry_reg     <= 1'b0;
            pc_reg        <= PC_RESET;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                zero_reg  <= ex.zero;
                carry_reg <= ex.carry;
                pc_reg    <= ex.pc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            ins_reg <= instruction;
            hi_reg  <= operand_high;
            lo_reg  <= operand_low;
            mem_reg <= memory_data;
        end
        if (advance)
        begin
            out_pc_reg   <= ex.pc;
            out_st_reg   <= ex.store_en;
            out_addr_reg <= ex.store_addr;
            out_data_reg <= ex.store_byte;
            out_acc_reg  <= ex.reg_we && (ex.reg_waddr == '0) ? ex.reg_wdata : reg_acc;
            out_z_reg    <= ex.zero;
            out_c_reg    <= ex.carry;
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pc       = out_pc_reg;
    assign store_valid   = out_st_reg;
    assign store_address = out_addr_reg;
    assign store_data    = out_data_reg;
    assign accumulator   = out_acc_reg;
    assign zero_flag     = out_z_reg;
    assign carry_flag    = out_c_reg;

endmodule

### dv/tb.sv
// Self-checking testbench for accumulator_cpu_execute: directed and random instructions,
// predicted with a cycle-free architectural model and compared field by field on every transfer.
// Depends on acpu_pkg and the accumulator_cpu_execute RTL.
`timescale 1ns / 1ps

module tb;
    import acpu_pkg::*;

    localparam logic [3:0] OP_IDLE  = 4'd0;
    localparam logic [3:0] OP_SPARE = 4'd9;
    localparam logic [3:0] OP_TOP   = 4'd15;
    localparam logic [RIDX_W-1:0] JC_ALWAYS = 3'd0;
    localparam logic MODE_IMM = 1'b0;
    localparam logic MODE_MEM = 1'b1;
    localparam int RANDOM_ITEMS = 450;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 64;

    typedef struct packed {
        logic [7:0] instruction;
        logic [7:0] operand_high;
        logic [7:0] operand_low;
        logic [7:0] memory_data;
    } cpu_instr_t;

    typedef struct packed {
        logic [15:0] next_pc;
        logic        store_valid;
        logic [15:0] store_address;
        logic [7:0]  store_data;
        logic [7:0]  accumulator;
        logic        zero_flag;
        logic        carry_flag;
    } exec_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  instruction = 8'h00;
    logic [7:0]  operand_high = 8'h00;
    logic [7:0]  operand_low = 8'h00;
    logic [7:0]  memory_data = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] next_pc;
    logic        store_valid;
    logic [15:0] store_address;
    logic [7:0]  store_data;
    logic [7:0]  accumulator;
    logic        zero_flag;
    logic        carry_flag;

    logic [7:0]  arch_regs [8];
    logic        arch_zero;
    logic        arch_carry;
    logic [15:0] arch_pc;

    cpu_instr_t   instr_queue [$];
    exec_result_t pending_results [$];

    int  error_count = 0;
    int  issued_count = 0;
    int  results_seen = 0;
    int  total_items = 0;
    int  idle_cycles = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    bit  idling_on = 1'b1;
    bit  long_hold_done = 1'b0;

    accumulator_cpu_execute dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .instruction   (instruction),
        .operand_high  (operand_high),
        .operand_low   (operand_low),
        .memory_data   (memory_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .next_pc       (next_pc),
        .store_valid   (store_valid),
        .store_address (store_address),
        .store_data    (store_data),
        .accumulator   (accumulator),
        .zero_flag     (zero_flag),
        .carry_flag    (carry_flag)
    );

    always #10 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at result %0d: %s", results_seen, msg);
        error_count++;
    endtask

    function automatic exec_result_t execute_instruction(input cpu_instr_t item);
        logic [3:0]        opc;
        logic [RIDX_W-1:0] ri;
        logic              mem_mode;
        logic [15:0]       target;
        logic [15:0]       pc_step;
        logic [7:0]        rv;
        logic [8:0]        sum;
        logic              take;
        exec_result_t      res;
        opc      = item.instruction[7:4];
        ri       = item.instruction[2:0];
        mem_mode = item.instruction[3];
        target   = {item.operand_high, item.operand_low};
        rv       = arch_regs[ri];
        pc_step  = mem_mode ? 16'd3 : 16'd1;
        res      = '0;
        case (opc)
            OP_LOAD:
            begin
                arch_regs[ri] = mem_mode ? item.memory_data : item.operand_high;
                pc_step = mem_mode ? 16'd3 : 16'd2;
            end
            OP_STORE:
            begin
                res.store_valid   = 1'b1;
                res.store_address = target;
                res.store_data    = rv;
                pc_step = 16'd3;
            end
            OP_ADD:
            begin
                sum = mem_mode ? {1'b0, rv} + {1'b0, item.memory_data}
                               : {1'b0, arch_regs[0]} + {1'b0, rv};
                arch_regs[0] = sum[7:0];
                arch_zero  = (sum[7:0] == 8'h00);
                arch_carry = sum[8];
            end
            OP_SUB:
            begin
                sum = mem_mode ? {1'b0, rv} - {1'b0, item.memory_data}
                               : {1'b0, arch_regs[0]} - {1'b0, rv};
                arch_regs[0] = sum[7:0];
                arch_zero  = (sum[7:0] == 8'h00);
                arch_carry = sum[8];
            end
            OP_JUMP:
            begin
                case (ri)
                    JC_ZERO:     take = arch_zero;
                    JC_CARRY:    take = arch_carry;
                    JC_EITHER:   take = arch_zero | arch_carry;
                    JC_NOT_ZERO: take = ~arch_zero;
                    default:     take = 1'b1;
                endcase
                if (take)
                begin
                    arch_pc    = target;
                    pc_step    = 16'd0;
                    arch_zero  = 1'b0;
                    arch_carry = 1'b0;
                end
                else
                begin
                    pc_step = 16'd3;
                end
            end
            OP_OR:
            begin
                arch_regs[0] = mem_mode ? (rv | item.memory_data) : (arch_regs[0] | rv);
                arch_zero  = (arch_regs[0] == 8'h00);
                arch_carry = 1'b0;
            end
            OP_NAND:
            begin
                arch_regs[0] = mem_mode ? ~(rv & item.memory_data) : ~(arch_regs[0] & rv);
                arch_zero  = (arch_regs[0] == 8'h00);
                arch_carry = 1'b0;
            end
            OP_CMP:
            begin
                sum = mem_mode ? {1'b0, item.memory_data} - {1'b0, rv}
                               : {1'b0, arch_regs[0]} - {1'b0, rv};
                arch_zero  = (sum == 9'd0);
                arch_carry = sum[8];
            end
            default:
            begin
                pc_step = 16'd1;
            end
        endcase
        arch_pc = arch_pc + pc_step;
        res.next_pc     = arch_pc;
        res.accumulator = arch_regs[0];
        res.zero_flag   = arch_zero;
        res.carry_flag  = arch_carry;
        return res;
    endfunction

    task automatic push_instr(input logic [7:0] ins, input logic [7:0] hi,
                              input logic [7:0] lo, input logic [7:0] mem);
        cpu_instr_t item;
        item = '{ins, hi, lo, mem};
        instr_queue.push_back(item);
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic cpu_instr_t random_instr();
        logic [3:0] opc;
        int         pick;
        cpu_instr_t item;
        pick = $urandom_range(0, 19);
        if (pick < 17)
        begin
            opc = OP_LOAD + 4'(pick % 8);
        end
        else
        begin
            opc = 4'($urandom_range(0, 15));
        end
        item.instruction  = {opc, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7))};
        item.operand_high = random_byte();
        item.operand_low  = random_byte();
        item.memory_data  = random_byte();
        return item;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : driver
        cpu_instr_t item;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            instruction  <= 8'h00;
            operand_high <= 8'h00;
            operand_low  <= 8'h00;
            memory_data  <= 8'h00;
            send_gap     = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                pending_results.push_back(
                    execute_instruction('{instruction, operand_high, operand_low, memory_data}));
                issued_count++;
            end
            if (!(in_valid && in_stall))
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (instr_queue.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (idling_on && $urandom_range(0, 9) == 0)
                begin
                    in_valid <= 1'b0;
                    send_gap = $urandom_range(0, 17);
                end
                else
                begin
                    item = instr_queue.pop_front();
                    in_valid     <= 1'b1;
                    instruction  <= item.instruction;
                    operand_high <= item.operand_high;
                    operand_low  <= item.operand_low;
                    memory_data  <= item.memory_data;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        exec_result_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("transfer with none pending, next_pc %h", next_pc));
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (next_pc !== want.next_pc)
                        report_mismatch($sformatf("next_pc %h want %h", next_pc, want.next_pc));
                    if (store_valid !== want.store_valid)
                        report_mismatch($sformatf("store_valid %b want %b",
                                                  store_valid, want.store_valid));
                    if (store_address !== want.store_address)
                        report_mismatch($sformatf("store_address %h want %h",
                                                  store_address, want.store_address));
                    if (store_data !== want.store_data)
                        report_mismatch($sformatf("store_data %h want %h",
                                                  store_data, want.store_data));
                    if (accumulator !== want.accumulator)
                        report_mismatch($sformatf("accumulator %h want %h",
                                                  accumulator, want.accumulator));
                    if (zero_flag !== want.zero_flag)
                        report_mismatch($sformatf("zero_flag %b want %b",
                                                  zero_flag, want.zero_flag));
                    if (carry_flag !== want.carry_flag)
                        report_mismatch($sformatf("carry_flag %b want %b",
                                                  carry_flag, want.carry_flag));
                end
                results_seen++;
            end
            if (!long_hold_done && results_seen >= 60)
            begin
                out_stall <= 1'b1;
                stall_left = LONG_HOLD - 1;
                long_hold_done = 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 17);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
            arch_regs[i] = 8'h00;
        arch_zero  = 1'b0;
        arch_carry = 1'b0;
        arch_pc    = PC_RESET;
        rst_n = 1'b0;

        push_instr({OP_LOAD, MODE_IMM, 3'd0}, 8'hFF, 8'h00, 8'h00);
        push_instr({OP_LOAD, MODE_MEM, 3'd1}, 8'h00, 8'h00, 8'h01);
        push_instr({OP_ADD, MODE_IMM, 3'd1}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_JUMP, MODE_IMM, JC_ZERO}, 8'hFF, 8'hFF, 8'h00);
        push_instr({OP_CMP, MODE_IMM, 3'd1}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_JUMP, MODE_MEM, JC_CARRY}, 8'h12, 8'h34, 8'h00);
        push_instr({OP_JUMP, MODE_IMM, JC_NOT_ZERO}, 8'h00, 8'h10, 8'h00);
        push_instr({OP_JUMP, MODE_IMM, JC_ZERO}, 8'hAB, 8'hCD, 8'h00);
        push_instr({OP_JUMP, MODE_IMM, JC_EITHER}, 8'hAB, 8'hCD, 8'h00);
        push_instr({OP_LOAD, MODE_IMM, 3'd7}, 8'h80, 8'hFF, 8'hFF);
        push_instr({OP_STORE, MODE_IMM, 3'd7}, 8'hFF, 8'hFF, 8'h00);
        push_instr({OP_STORE, MODE_MEM, 3'd1}, 8'h00, 8'h00, 8'hFF);
        push_instr({OP_ADD, MODE_MEM, 3'd7}, 8'h40, 8'h00, 8'h80);
        push_instr({OP_JUMP, MODE_IMM, JC_EITHER}, 8'hFF, 8'hFE, 8'h00);
        push_instr({OP_SUB, MODE_IMM, 3'd7}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_SUB, MODE_MEM, 3'd1}, 8'h00, 8'h01, 8'h01);
        push_instr({OP_JUMP, MODE_IMM, JC_ALWAYS}, 8'h00, 8'hAA, 8'h00);
        push_instr({OP_OR, MODE_IMM, 3'd7}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_OR, MODE_MEM, 3'd2}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_LOAD, MODE_IMM, 3'd3}, 8'hFF, 8'h00, 8'h00);
        push_instr({OP_NAND, MODE_MEM, 3'd3}, 8'h00, 8'h00, 8'hFF);
        push_instr({OP_NAND, MODE_IMM, 3'd0}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_CMP, MODE_MEM, 3'd3}, 8'h00, 8'h00, 8'hFF);
        push_instr({OP_IDLE, MODE_MEM, 3'd5}, 8'hFF, 8'hFF, 8'hFF);
        push_instr({OP_SPARE, MODE_IMM, 3'd2}, 8'h00, 8'h00, 8'h00);
        push_instr({OP_TOP, MODE_MEM, 3'd7}, 8'hFF, 8'hFF, 8'hFF);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            instr_queue.push_back(random_instr());
        total_items = instr_queue.size();

        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        while (instr_queue.size() >= 50)
            @(negedge clk);
        idling_on = 1'b0;

        while (issued_count < total_items || pending_results.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
